/* hdl/gcd_pkg.sv */
// Shared types and constants for the genome compatibility distance block.
// No dependencies; imported by the top module, the front end and the back end.
`default_nettype none

package gcd_pkg;

   localparam int INNOV_W  = 24;
   localparam int WEIGHT_W = 17;
   localparam int GENE_W   = INNOV_W + WEIGHT_W;
   localparam int COEF_W   = 16;
   localparam int DIST_W   = 18;
   localparam int LIMIT_W  = 13;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [DIST_W-1:0] DIST_MAX = 18'h3FFFF;
   localparam int MATCH_SAT  = 511;
   localparam int COUNT_SAT  = 1023;

   typedef enum logic [1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_EXCESS_COEFF   = 3'd0,
      CSR_DISJOINT_COEFF = 3'd1,
      CSR_WEIGHT_COEFF   = 3'd2,
      CSR_THRESHOLD      = 3'd3,
      CSR_SMALL_LIMIT    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      TERM_EXCESS   = 2'd0,
      TERM_DISJOINT = 2'd1,
      TERM_WEIGHT   = 2'd2
   } term_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_COMPARE,
      BK_PREP,
      BK_MUL,
      BK_DIV_GO,
      BK_DIV_WAIT,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic [COEF_W-1:0]  excess_coeff;
      logic [COEF_W-1:0]  disjoint_coeff;
      logic [COEF_W-1:0]  weight_coeff;
      logic [DIST_W-1:0]  species_threshold;
      logic [LIMIT_W-1:0] small_genome_limit;
   } cfg_type;

   typedef struct packed {
      op_type                      op;
      logic [INNOV_W-1:0]          innovation;
      logic signed [WEIGHT_W-1:0]  weight;
   } item_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              same_species;
      logic [8:0]        matching_count;
      logic [9:0]        disjoint_count;
      logic [9:0]        excess_count;
      logic              overflow;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/genome_compatibility_distance.sv */
// Genome compatibility distance: two gene lists are loaded one gene per request,
// and a compute request merge-walks both lists and returns the distance.
//
// Request channel (req_): tuser carries the opcode (load into A, load into B,
// compute and clear; the fourth code is taken and ignored). tdata carries the
// gene's innovation number and signed Q.12 weight. Loads return nothing.
// Response channel (rsp_): one response per compute request with the distance,
// the species flag, the three gene counts and the overflow flag.
// Register port (csr_): five registers, always ready; the user writes them only
// while idle, and the block does not enforce this.
// Loads are taken one per cycle through a four-entry queue while it has room. A
// compute request runs the merge walk, a registered RAM read and a compare per
// step, then scales and divides the excess, disjoint and weight terms in turn
// on the bit-serial divider, whose width is W = clog2(MAX_GENES+1)+21 (30 at
// 256 genes); the weight division is skipped when no genes match.
// Reset empties both lists and the queue and restores the register defaults;
// stored genes are not cleared. A stalled response holds in its output
// register while loads are still taken; a second compute's response waits.
`default_nettype none

module genome_compatibility_distance #(
   parameter int MAX_GENES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [23:0] gene_innovation, [40:24] gene_weight
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [17:0] distance, [18] same_species, [27:19] matching_count,
   // [37:28] disjoint_count, [47:38] excess_count, [48] overflow
   output logic [55:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [17:0] csr_data
);
   import gcd_pkg::*;

   cfg_type  cfg_ff;
   item_type req_item;
   item_type item;
   logic     item_valid, item_pop;
   rsp_type  rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.excess_coeff       <= 16'd4096;
         cfg_ff.disjoint_coeff     <= 16'd4096;
         cfg_ff.weight_coeff       <= 16'd1638;
         cfg_ff.species_threshold  <= 18'd12288;
         cfg_ff.small_genome_limit <= 13'd20;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_EXCESS_COEFF:   cfg_ff.excess_coeff       <= csr_data[COEF_W-1:0];
            CSR_DISJOINT_COEFF: cfg_ff.disjoint_coeff     <= csr_data[COEF_W-1:0];
            CSR_WEIGHT_COEFF:   cfg_ff.weight_coeff       <= csr_data[COEF_W-1:0];
            CSR_THRESHOLD:      cfg_ff.species_threshold  <= csr_data[DIST_W-1:0];
            CSR_SMALL_LIMIT:    cfg_ff.small_genome_limit <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_item.op         = op_type'(req_tuser);
   assign req_item.innovation = req_tdata[INNOV_W-1:0];
   assign req_item.weight     = req_tdata[GENE_W-1:INNOV_W];

   gcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   gcd_back #(.MAX_GENES(MAX_GENES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {7'd0, rsp.overflow, rsp.excess_count, rsp.disjoint_count,
                       rsp.matching_count, rsp.same_species, rsp.distance};

endmodule

`default_nettype wire

/* hdl/gcd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/gcd_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the three terms.
// Depends on nothing; the divisor must be nonzero.
`default_nettype none

module gcd_div #(
   parameter int DIVIDEND_W = 30,
   parameter int DIVISOR_W  = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* hdl/gcd_front.sv */
// Front end: accepts requests, drops unused opcodes, queues the rest.
// Depends on gcd_pkg.
`default_nettype none

module gcd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  gcd_pkg::item_type   req_item,
   output logic                item_valid,
   output gcd_pkg::item_type   item,
   input  logic                item_pop
);
   import gcd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   assign req_ready  = count_ff != CNT_W'(QUEUE_DEPTH);
   // Unused opcodes are taken and dropped here.
   assign push       = req_valid && req_ready && (req_item.op != OP_NONE);
   assign item_valid = count_ff != '0;
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = item_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !item_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && item_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

`default_nettype wire

/* hdl/gcd_back.sv */
// Back end: gene stores, merge walk, term arithmetic and result register.
// Depends on gcd_pkg, gcd_ram and gcd_div.
`default_nettype none

module gcd_back #(
   parameter int MAX_GENES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  gcd_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  gcd_pkg::item_type item,
   output logic              item_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gcd_pkg::rsp_type  rsp
);
   import gcd_pkg::*;

   localparam int AW     = $clog2(MAX_GENES);
   localparam int LW     = $clog2(MAX_GENES + 1);
   localparam int CW     = LW + 1;
   localparam int SW     = WEIGHT_W + LW;
   localparam int PW     = SW + COEF_W;
   localparam int DW     = SW + 4;
   localparam int ACC_W  = DW + 2;

   back_state_type state_ff, state_in;

   logic [LW-1:0]  len_a_ff, len_b_ff;
   logic           dropped_ff;
   logic [LW-1:0]  ia_ff, ib_ff;
   logic [LW-1:0]  match_ff;
   logic [CW-1:0]  disj_ff;
   logic [CW-1:0]  excess_ff;
   logic [SW-1:0]  sum_ff;
   logic [LW-1:0]  n_ff;
   term_type       term_ff;
   logic [PW-1:0]  prod_ff;
   logic [ACC_W-1:0] acc_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   logic           pop_i, we_a, we_b, div_start, emit, out_free;
   logic           full_a, full_b;
   logic [GENE_W-1:0] rd_a, rd_b;
   logic           div_done;
   logic [DW-1:0]  div_q;
   logic [DW-1:0]  dividend;
   logic [LW-1:0]  divisor;

   // Walk step signals.
   logic [INNOV_W-1:0]        xa, xb;
   logic signed [WEIGHT_W:0]  diff;
   logic [WEIGHT_W:0]         abs_diff;
   logic [LW-1:0]             ia_nx, ib_nx;
   logic                      walk_end;

   // Arithmetic signals.
   logic [LW-1:0]     n_max;
   logic              n_small;
   logic [SW-1:0]     mul_a;
   logic [COEF_W-1:0] mul_b;
   logic              skip_weight;
   logic [ACC_W-1:0]  acc_sum;

   assign full_a   = len_a_ff == LW'(MAX_GENES);
   assign full_b   = len_b_ff == LW'(MAX_GENES);
   assign out_free = !rsp_valid_ff || rsp_ready;

   gcd_ram #(.WIDTH(GENE_W), .DEPTH(MAX_GENES)) u_ram_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (len_a_ff[AW-1:0]),
      .wr_data ({item.innovation, item.weight}),
      .rd_addr (ia_ff[AW-1:0]),
      .rd_data (rd_a)
   );

   gcd_ram #(.WIDTH(GENE_W), .DEPTH(MAX_GENES)) u_ram_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (len_b_ff[AW-1:0]),
      .wr_data ({item.innovation, item.weight}),
      .rd_addr (ib_ff[AW-1:0]),
      .rd_data (rd_b)
   );

   gcd_div #(.DIVIDEND_W(DW), .DIVISOR_W(LW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // Merge step on the data read in the previous cycle.
   always_comb begin
      xa       = rd_a[GENE_W-1:WEIGHT_W];
      xb       = rd_b[GENE_W-1:WEIGHT_W];
      diff     = $signed({rd_a[WEIGHT_W-1], rd_a[WEIGHT_W-1:0]})
               - $signed({rd_b[WEIGHT_W-1], rd_b[WEIGHT_W-1:0]});
      abs_diff = diff[WEIGHT_W] ? (WEIGHT_W+1)'(-diff) : diff;
      ia_nx    = (xa <= xb) ? ia_ff + LW'(1) : ia_ff;
      ib_nx    = (xb <= xa) ? ib_ff + LW'(1) : ib_ff;
      walk_end = (ia_nx == len_a_ff) || (ib_nx == len_b_ff);
   end

   always_comb begin
      n_max   = (len_a_ff > len_b_ff) ? len_a_ff : len_b_ff;
      n_small = (32'(n_max) < 32'(cfg.small_genome_limit)) || (n_max == '0);
      unique case (term_ff)
         TERM_EXCESS: begin
            mul_a = SW'(excess_ff);
            mul_b = cfg.excess_coeff;
         end
         TERM_DISJOINT: begin
            mul_a = SW'(disj_ff);
            mul_b = cfg.disjoint_coeff;
         end
         default: begin
            mul_a = sum_ff;
            mul_b = cfg.weight_coeff;
         end
      endcase
      // Weight term divides by matching * 4096: drop the low 12 bits first.
      if (term_ff == TERM_WEIGHT) begin
         dividend = prod_ff[PW-1:12];
         divisor  = match_ff;
      end else begin
         dividend = DW'(prod_ff);
         divisor  = n_ff;
      end
      skip_weight = (term_ff == TERM_WEIGHT) && (match_ff == '0);
      acc_sum     = acc_ff + ACC_W'(div_q);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (item_valid && item.op == OP_COMPUTE) begin
               state_in = (len_a_ff != '0 && len_b_ff != '0) ? BK_READ : BK_PREP;
            end
         end
         BK_READ:    state_in = BK_COMPARE;
         BK_COMPARE: state_in = walk_end ? BK_PREP : BK_READ;
         BK_PREP:    state_in = BK_MUL;
         BK_MUL:     state_in = skip_weight ? BK_EMIT : BK_DIV_GO;
         BK_DIV_GO:  state_in = BK_DIV_WAIT;
         BK_DIV_WAIT: begin
            if (div_done) begin
               state_in = (term_ff == TERM_WEIGHT) ? BK_EMIT : BK_MUL;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      pop_i     = (state_ff == BK_IDLE) && item_valid;
      we_a      = pop_i && (item.op == OP_LOAD_A) && !full_a;
      we_b      = pop_i && (item.op == OP_LOAD_B) && !full_b;
      div_start = state_ff == BK_DIV_GO;
      emit      = (state_ff == BK_EMIT) && out_free;
   end

   assign item_pop = pop_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (we_a) begin
            len_a_ff <= len_a_ff + LW'(1);
         end
         if (we_b) begin
            len_b_ff <= len_b_ff + LW'(1);
         end
         if (pop_i && ((item.op == OP_LOAD_A && full_a) ||
                       (item.op == OP_LOAD_B && full_b))) begin
            dropped_ff <= 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            len_a_ff     <= '0;
            len_b_ff     <= '0;
            dropped_ff   <= 1'b0;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (pop_i && item.op == OP_COMPUTE) begin
         ia_ff    <= '0;
         ib_ff    <= '0;
         match_ff <= '0;
         disj_ff  <= '0;
         sum_ff   <= '0;
      end
      if (state_ff == BK_COMPARE) begin
         ia_ff <= ia_nx;
         ib_ff <= ib_nx;
         if (xa == xb) begin
            match_ff <= match_ff + LW'(1);
            sum_ff   <= sum_ff + SW'(abs_diff);
         end else begin
            disj_ff <= disj_ff + CW'(1);
         end
      end
      if (state_ff == BK_PREP) begin
         excess_ff <= CW'(len_a_ff - ia_ff) + CW'(len_b_ff - ib_ff);
         n_ff      <= n_small ? LW'(1) : n_max;
         term_ff   <= TERM_EXCESS;
         acc_ff    <= '0;
      end
      if (state_ff == BK_MUL) begin
         prod_ff <= PW'(mul_a) * PW'(mul_b);
      end
      if (state_ff == BK_DIV_WAIT && div_done) begin
         acc_ff <= acc_sum;
         unique case (term_ff)
            TERM_EXCESS:   term_ff <= TERM_DISJOINT;
            TERM_DISJOINT: term_ff <= TERM_WEIGHT;
            default:       term_ff <= TERM_WEIGHT;
         endcase
      end
      if (emit) begin
         rsp_ff.distance       <= (acc_ff > ACC_W'(DIST_MAX)) ? DIST_MAX
                                                               : acc_ff[DIST_W-1:0];
         rsp_ff.same_species   <= (acc_ff > ACC_W'(DIST_MAX) ? DIST_MAX
                                   : acc_ff[DIST_W-1:0]) < cfg.species_threshold;
         rsp_ff.matching_count <= (32'(match_ff) > MATCH_SAT) ? 9'(MATCH_SAT)
                                                              : 9'(match_ff);
         rsp_ff.disjoint_count <= (32'(disj_ff) > COUNT_SAT) ? 10'(COUNT_SAT)
                                                             : 10'(disj_ff);
         rsp_ff.excess_count   <= (32'(excess_ff) > COUNT_SAT) ? 10'(COUNT_SAT)
                                                               : 10'(excess_ff);
         rsp_ff.overflow       <= dropped_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire
